@@ rtl/i2cm_pkg.sv @@
// Shared types, command codes and register indexes of the I2C master bit engine.
package i2cm_pkg;

  localparam int CfgWidth = 8;
  localparam int CfgIdxWidth = 1;

  localparam logic [CfgIdxWidth-1:0] CFG_TICKS_PER_US = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_ACK_POLL_LIMIT = 1'd1;

  localparam logic [7:0] TICKS_PER_US_RST = 8'd1;
  localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_ACK   = 3'd5;
  localparam logic [2:0] OP_NACK  = 3'd6;
  localparam logic [2:0] OP_WAIT  = 3'd7;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_timeout;
  } out_item_t;

  // Classified item as it sits in the queue between front and back.
  typedef struct packed {
    logic       start_req;
    logic [2:0] op;
    logic [7:0] wdata;
    logic       sda;
  } q_item_t;

endpackage

@@ rtl/i2cm_front.sv @@
// Input side: accepts items, classifies the command and queues them for the sequencer.
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output q_item_t  q_item
);

  q_item_t    q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  q_item_t    cls;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    cls.start_req = (in_data.operation != OP_NONE);
    cls.op        = in_data.operation;
    cls.wdata     = in_data.write_data;
    cls.sda       = in_data.sda_in;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/i2cm_back.sv @@
// Bus sequencer: runs the pin sequences one tick per item and registers each result.
module i2cm_back
  import i2cm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_wdata,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  q_item_t                q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data
);

  logic [7:0] tpm_r;
  logic [7:0] poll_lim_r;

  logic [2:0] cmd_r, cmd_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [9:0] delay_r, delay_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       en_r, en_nxt;
  logic       tmo_r, tmo_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic       done;
  logic [3:0] bit_inc;
  logic       fire;
  logic       out_valid_r;
  out_item_t  out_r;

  // Hold length in ticks for 1, 2 or 4 delay units.
  function automatic logic [9:0] hold_len(input logic [1:0] sh, input logic [7:0] tpm);
    hold_len = {2'b00, tpm} << sh;
  endfunction

  assign fire      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign bit_inc   = bit_r + 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r      <= TICKS_PER_US_RST;
      poll_lim_r <= ACK_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_US:   tpm_r      <= cfg_wdata;
        CFG_ACK_POLL_LIMIT: poll_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    delay_nxt = delay_r;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    en_nxt    = en_r;
    tmo_nxt   = tmo_r;
    rd_nxt    = rd_r;
    done      = 1'b0;

    if (cmd_r == OP_NONE) begin
      if (q_item.start_req) begin
        cmd_nxt   = q_item.op;
        bit_nxt   = 4'd0;
        poll_nxt  = 8'd0;
        phase_nxt = 2'd0;
        unique case (q_item.op)
          OP_START: begin
            en_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1;
            delay_nxt = hold_len(2'd2, tpm_r);
          end
          OP_STOP: begin
            en_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
            delay_nxt = hold_len(2'd2, tpm_r);
          end
          OP_WRITE: begin
            en_nxt = 1'b1; scl_nxt = 1'b0;
            sda_nxt   = q_item.wdata[7];
            shift_nxt = {q_item.wdata[6:0], 1'b0};
            delay_nxt = hold_len(2'd1, tpm_r);
          end
          OP_READ: begin
            en_nxt = 1'b0; scl_nxt = 1'b0; shift_nxt = 8'd0;
            delay_nxt = hold_len(2'd1, tpm_r);
          end
          OP_ACK, OP_NACK: begin
            scl_nxt = 1'b0; en_nxt = 1'b1;
            sda_nxt = (q_item.op == OP_NACK);
            delay_nxt = hold_len(2'd1, tpm_r);
          end
          default: begin
            tmo_nxt = 1'b0; en_nxt = 1'b0; sda_nxt = 1'b1;
            delay_nxt = hold_len(2'd0, tpm_r);
          end
        endcase
      end
    end else if (cmd_r == OP_WAIT && phase_r == 2'd2) begin
      // Acknowledge poll: low SDA ends the command, too many highs force a stop.
      if (!q_item.sda) begin
        scl_nxt = 1'b0;
        cmd_nxt = OP_NONE; phase_nxt = 2'd0; delay_nxt = 10'd0; done = 1'b1;
      end else if (poll_r >= poll_lim_r) begin
        tmo_nxt = 1'b1;
        cmd_nxt = OP_STOP; en_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
        phase_nxt = 2'd0; delay_nxt = hold_len(2'd2, tpm_r);
      end else begin
        poll_nxt = poll_r + 8'd1;
      end
    end else if (delay_r > 10'd1) begin
      delay_nxt = delay_r - 10'd1;
    end else begin
      unique case (cmd_r)
        OP_START: begin
          if (phase_r == 2'd0) begin
            sda_nxt = 1'b0; phase_nxt = 2'd1; delay_nxt = hold_len(2'd2, tpm_r);
          end else begin
            scl_nxt = 1'b0;
            cmd_nxt = OP_NONE; phase_nxt = 2'd0; delay_nxt = 10'd0; done = 1'b1;
          end
        end
        OP_STOP: begin
          if (phase_r == 2'd0) begin
            scl_nxt = 1'b1; sda_nxt = 1'b1;
            phase_nxt = 2'd1; delay_nxt = hold_len(2'd2, tpm_r);
          end else begin
            cmd_nxt = OP_NONE; phase_nxt = 2'd0; delay_nxt = 10'd0; done = 1'b1;
          end
        end
        OP_WRITE: begin
          if (phase_r == 2'd0) begin
            scl_nxt = 1'b1; phase_nxt = 2'd1; delay_nxt = hold_len(2'd1, tpm_r);
          end else if (phase_r == 2'd1) begin
            scl_nxt = 1'b0; phase_nxt = 2'd2; delay_nxt = hold_len(2'd1, tpm_r);
          end else begin
            bit_nxt = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              cmd_nxt = OP_NONE; phase_nxt = 2'd0; delay_nxt = 10'd0; done = 1'b1;
            end else begin
              sda_nxt   = shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
              phase_nxt = 2'd0;
              delay_nxt = hold_len(2'd1, tpm_r);
            end
          end
        end
        OP_READ: begin
          if (phase_r == 2'd0) begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_r[6:0], q_item.sda};
            phase_nxt = 2'd1;
            delay_nxt = hold_len(2'd0, tpm_r);
          end else begin
            bit_nxt = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              rd_nxt  = shift_r;
              cmd_nxt = OP_NONE; phase_nxt = 2'd0; delay_nxt = 10'd0; done = 1'b1;
            end else begin
              scl_nxt = 1'b0; phase_nxt = 2'd0; delay_nxt = hold_len(2'd1, tpm_r);
            end
          end
        end
        OP_ACK, OP_NACK: begin
          if (phase_r == 2'd0) begin
            scl_nxt = 1'b1; phase_nxt = 2'd1; delay_nxt = hold_len(2'd1, tpm_r);
          end else begin
            scl_nxt = 1'b0;
            cmd_nxt = OP_NONE; phase_nxt = 2'd0; delay_nxt = 10'd0; done = 1'b1;
          end
        end
        OP_WAIT: begin
          if (phase_r == 2'd0) begin
            scl_nxt = 1'b1; phase_nxt = 2'd1; delay_nxt = hold_len(2'd0, tpm_r);
          end else begin
            // First poll happens on the tick that ends the SCL-high hold.
            phase_nxt = 2'd2;
            if (!q_item.sda) begin
              scl_nxt = 1'b0;
              cmd_nxt = OP_NONE; phase_nxt = 2'd0; delay_nxt = 10'd0; done = 1'b1;
            end else if (poll_r >= poll_lim_r) begin
              tmo_nxt = 1'b1;
              cmd_nxt = OP_STOP; en_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
              phase_nxt = 2'd0; delay_nxt = hold_len(2'd2, tpm_r);
            end else begin
              poll_nxt = poll_r + 8'd1;
            end
          end
        end
        default: begin
          cmd_nxt = OP_NONE; phase_nxt = 2'd0; delay_nxt = 10'd0; done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= OP_NONE;
      phase_r     <= 2'd0;
      bit_r       <= 4'd0;
      delay_r     <= 10'd0;
      shift_r     <= 8'd0;
      poll_r      <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      en_r        <= 1'b1;
      tmo_r       <= 1'b0;
      rd_r        <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        cmd_r   <= cmd_nxt;
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        delay_r <= delay_nxt;
        shift_r <= shift_nxt;
        poll_r  <= poll_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        en_r    <= en_nxt;
        tmo_r   <= tmo_nxt;
        rd_r    <= rd_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.scl_out     <= scl_nxt;
      out_r.sda_out     <= sda_nxt;
      out_r.sda_drive   <= en_nxt;
      out_r.busy_res    <= (cmd_nxt != OP_NONE);
      out_r.done_res    <= done;
      out_r.read_data   <= rd_nxt;
      out_r.ack_timeout <= tmo_nxt;
    end
  end

endmodule

@@ rtl/i2c_master_bit_engine_top.sv @@
// Top level of the I2C master bit engine: input queue front and bus sequencer back.
//
// Each input item is one timing tick: an optional command, a byte to write and
// the sampled SDA level. Each accepted item yields exactly one result item with
// the SCL/SDA levels, SDA drive enable, busy, done, read byte and timeout flag
// as they stand after that tick.
// Both channels use valid/ready. An item is written into the two-entry queue at
// the edge that accepted it, and the sequencer loads its result from the queue
// into the output register at a later edge on which the output is not stalled.
// Throughput is one item per clock while the receiver does not stall, limited by
// the one-tick-per-cycle sequencer update.
// When the receiver stalls, the result holds in the output register and the
// queue absorbs up to two more items before in_ready drops.
// The configuration registers (index 0 ticks per microsecond, index 1 poll limit)
// are written via cfg_we/cfg_index/cfg_wdata by the user only while no item is in flight,
// unchecked by the block. A synchronous low rst_n empties the queue, drops out_valid,
// returns the sequencer to idle with SCL and SDA high and loads the register defaults.
module i2c_master_bit_engine_top
  import i2cm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_wdata
);

  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/i2cm_checker.sv @@
// Port-level checks of the I2C master bit engine, bound to the top level.
module i2cm_checker
  import i2cm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A held result must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The finishing tick always reports the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while busy");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An item accepted while no result waits always yields a result through the queue and output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after accepted item");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_chk (.*);
